>>> hdl/allpass_chain_phaser_macros.svh
// assertion macros for the phaser block
`ifndef ALLPASS_CHAIN_PHASER_MACROS_SVH
`define ALLPASS_CHAIN_PHASER_MACROS_SVH

// same-cycle implication, checked outside reset
`define APC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("phaser assertion failed");

// next-cycle implication, checked outside reset
`define APC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("phaser assertion failed");

`endif

>>> hdl/apc_pkg.sv
// shared types, constants and the lfo shape table of the phaser
`default_nettype none
package apc_pkg;

    localparam int MAX_STAGES          = 24;
    localparam int STAGE_W             = 5;
    localparam int LFO_UPDATE_INTERVAL = 20;
    localparam int UPD_CNT_W           = 5;
    localparam int LFO_TABLE_DEPTH     = 1024;
    localparam int LFO_IDX_W           = 10;
    localparam int SHAPE_W             = 17;
    localparam int GAIN_ONE            = 65536;
    localparam int GAIN_SHIFT          = 16;
    localparam int OUT_SHIFT           = 13;
    localparam int FB_DIVISOR          = 101;
    localparam int MIX_DIVISOR         = 255;
    localparam int DEG_DIVISOR         = 360;

    localparam int MUL_A_W     = 42;
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_DIGITS  = 5;
    localparam int MUL_B_W     = MUL_DIGIT_W * MUL_DIGITS;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W   = 3;

    localparam int DIV_N_W   = 44;
    localparam int DIV_D_W   = 9;
    localparam int DIV_CNT_W = 6;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic [MUL_B_W-1:0]        mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;
    typedef logic [DIV_N_W-1:0]        div_n_t;
    typedef logic [DIV_D_W-1:0]        div_d_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_STAGE_COUNT = 3'd0,
        REG_DRY_WET     = 3'd1,
        REG_LFO_STEP    = 3'd2,
        REG_START_PHASE = 3'd3,
        REG_DEPTH       = 3'd4,
        REG_FEEDBACK    = 3'd5,
        REG_OUT_GAIN    = 3'd6
    } cfg_reg_t;

    localparam longint unsigned FX_ONE    = 64'd1 << 28;
    localparam longint unsigned FX_TWO_PI = 64'd1686629713;

    // unsigned quotient by shift and subtract, only used to build the table
    function automatic longint unsigned udiv_c(input longint unsigned num,
                                               input longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            quo = quo << 1;
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // e^(4v) in q28, as (taylor of e^v)^4
    function automatic longint unsigned exp4_fx(input longint unsigned v);
        longint unsigned sum;
        longint unsigned term;
        sum  = FX_ONE;
        term = FX_ONE;
        for (int k = 1; k <= 14; k++) begin
            term = udiv_c((term * v) >> 28, 64'(k));
            sum  = sum + term;
        end
        sum = (sum * sum) >> 28;
        sum = (sum * sum) >> 28;
        return sum;
    endfunction

    // cos of t in 2^-32 turns, q28
    function automatic longint cos_fx(input longint unsigned t_in);
        longint unsigned t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          s;
        logic            neg;
        t    = t_in;
        neg  = 1'b0;
        term = FX_ONE;
        s    = longint'(FX_ONE);
        if (t > (64'd1 << 31)) t = (64'd1 << 32) - t;
        if (t > (64'd1 << 30)) begin
            t   = (64'd1 << 31) - t;
            neg = 1'b1;
        end
        x  = (t * FX_TWO_PI) >> 32;
        x2 = (x * x) >> 28;
        for (int k = 1; k <= 10; k++) begin
            term = udiv_c((term * x2) >> 28, 64'((2 * k - 1) * (2 * k)));
            if ((k % 2) == 1) s = s - longint'(term);
            else s = s + longint'(term);
        end
        if (s < 0) s = 0;
        if (s > longint'(FX_ONE)) s = longint'(FX_ONE);
        return neg ? -s : s;
    endfunction

    function automatic logic [SHAPE_W-1:0] shape_entry(input int idx);
        longint unsigned t;
        longint          c;
        longint unsigned v;
        longint unsigned e;
        longint unsigned den;
        longint unsigned sh;
        t   = (longint'(idx) << 32) / LFO_TABLE_DEPTH;
        c   = cos_fx(t);
        v   = longint'(FX_ONE + c) >> 1;
        e   = exp4_fx(v);
        den = exp4_fx(FX_ONE) - FX_ONE;
        sh  = udiv_c((e - FX_ONE) << 16, den);
        if (sh > GAIN_ONE) sh = GAIN_ONE;
        return sh[SHAPE_W-1:0];
    endfunction

    typedef logic [SHAPE_W-1:0] lfo_table_t [LFO_TABLE_DEPTH];

    function automatic lfo_table_t build_lfo_table();
        lfo_table_t tab;
        for (int i = 0; i < LFO_TABLE_DEPTH; i++) tab[i] = shape_entry(i);
        return tab;
    endfunction

    localparam lfo_table_t LFO_TABLE = build_lfo_table();

    localparam mul_p_t SAT32_HI = mul_p_t'(64'sd2147483647);
    localparam mul_p_t SAT32_LO = -SAT32_HI - mul_p_t'(1);
    localparam mul_p_t SAT24_HI = mul_p_t'(64'sd8388607);
    localparam mul_p_t SAT24_LO = -SAT24_HI - mul_p_t'(1);

    function automatic logic signed [31:0] sat32(input mul_p_t v);
        mul_p_t r;
        r = (v > SAT32_HI) ? SAT32_HI : ((v < SAT32_LO) ? SAT32_LO : v);
        return r[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input mul_p_t v);
        mul_p_t r;
        r = (v > SAT24_HI) ? SAT24_HI : ((v < SAT24_LO) ? SAT24_LO : v);
        return r[23:0];
    endfunction

    // p / 65536 truncated toward zero
    function automatic mul_p_t trunc_gain(input mul_p_t p);
        mul_p_t mag;
        mag = (p < 0) ? -p : p;
        mag = mag >>> GAIN_SHIFT;
        return (p < 0) ? -mag : mag;
    endfunction

endpackage
`default_nettype wire

>>> hdl/apc_mul.sv
// digit-serial signed by unsigned multiplier, one 4-bit digit per cycle
`default_nettype none
module apc_mul import apc_pkg::*; (
    input  wire    aclk,
    input  wire    aresetn,
    input  wire    start,
    input  mul_a_t a,
    input  mul_b_t b,
    output logic   done,
    output mul_p_t p
);

    mul_a_t               a_reg;
    mul_b_t               b_reg;
    mul_p_t               acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_DIGIT_W-1:0] digit;
    mul_p_t               part;

    assign digit = b_reg[MUL_B_W-1 -: MUL_DIGIT_W];
    assign part  = mul_p_t'(a_reg) * mul_p_t'($signed({1'b0, digit}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= MUL_CNT_W'(MUL_DIGITS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // msb digit first
                acc_reg <= (acc_reg <<< MUL_DIGIT_W) + part;
                b_reg   <= b_reg << MUL_DIGIT_W;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule
`default_nettype wire

>>> hdl/apc_div.sv
// bit-serial restoring divider by a small constant divisor
`default_nettype none
module apc_div import apc_pkg::*; (
    input  wire    aclk,
    input  wire    aresetn,
    input  wire    start,
    input  div_n_t n,
    input  div_d_t d,
    output logic   done,
    output div_n_t q
);

    div_n_t               n_reg;
    div_d_t               d_reg;
    logic [DIV_D_W-1:0]   r_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     r_shift;
    logic [DIV_D_W:0]     r_sub;
    logic                 ge;

    assign r_shift = {r_reg, n_reg[DIV_N_W-1]};
    assign ge      = r_shift >= {1'b0, d_reg};
    assign r_sub   = r_shift - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= n;
                d_reg    <= d;
                r_reg    <= '0;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // quotient bits shift in where dividend bits leave
                r_reg   <= ge ? r_sub[DIV_D_W-1:0] : r_shift[DIV_D_W-1:0];
                n_reg   <= {n_reg[DIV_N_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = n_reg;

endmodule
`default_nettype wire

>>> hdl/allpass_chain_phaser.sv
// Phaser: feedback add, chain of first-order allpass stages with an LFO-driven
// coefficient, dry/wet mix and output gain with 24-bit saturation. One sample
// is worked at a time. Products go through a multiplier that takes one 4-bit
// digit per cycle, and the constant divisions through a 1-bit-per-cycle
// divider. The LFO coefficient is recomputed on every 20th sample, and a
// stalled output holds the next result back until it is taken. A result
// waits in the output register while the next sample is already taken in.
`default_nettype none
`include "allpass_chain_phaser_macros.svh"
module allpass_chain_phaser import apc_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // in_sample [23:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // out_sample [23:0]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_FBMUL, S_FBDIV, S_OFFDIV, S_TAB, S_DEPST, S_DEPMUL, S_DEPDIV,
        S_ST1, S_ST1W, S_ST2W, S_MIXST, S_MIX1, S_MIX2, S_GAIN, S_ODIV
    } state_t;

    // configuration
    logic [4:0]         stage_count_reg;
    logic [7:0]         dry_wet_reg;
    logic [31:0]        lfo_step_reg;
    logic [8:0]         start_phase_reg;
    logic [7:0]         depth_reg;
    logic signed [7:0]  feedback_reg;
    logic [15:0]        out_gain_reg;

    state_t                   state_reg;
    logic [STAGE_W-1:0]       n_reg;
    logic [STAGE_W-1:0]       prev_reg;
    logic [STAGE_W-1:0]       stage_reg;
    logic [MAX_STAGES-1:0]    valid_reg;
    logic signed [31:0]       mem_reg [MAX_STAGES];
    logic signed [31:0]       fv_reg;
    logic [SHAPE_W-1:0]       g_reg;
    logic [UPD_CNT_W-1:0]     cnt_reg;
    logic [31:0]              angle_reg;
    logic                     upd_reg;
    logic signed [23:0]       dry_reg;
    logic signed [33:0]       m_reg;
    logic signed [31:0]       old_reg;
    logic [LFO_IDX_W-1:0]     idx_reg;
    logic [SHAPE_W-1:0]       shape_reg;
    mul_p_t                   mix1_reg;
    logic                     neg_reg;
    logic                     qrdy_reg;
    logic                     out_valid_reg;
    logic [23:0]              out_data_reg;

    logic   mul_start_reg;
    mul_a_t mul_a_reg;
    mul_b_t mul_b_reg;
    logic   mul_done;
    mul_p_t mul_p;
    logic   div_start_reg;
    div_n_t div_n_reg;
    div_d_t div_d_reg;
    logic   div_done;
    div_n_t div_q;

    logic [STAGE_W-1:0] n_new;
    logic               s_acc;
    logic [7:0]         fb_mag;
    logic               out_load;
    logic signed [31:0] old_sel;
    mul_p_t             mul_mag;
    mul_p_t             q_signed;
    logic signed [31:0] nw;
    logic signed [31:0] m_sat;
    mul_p_t             mix_sum;
    logic [31:0]        ang;

    apc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .a(mul_a_reg), .b(mul_b_reg), .done(mul_done), .p(mul_p)
    );

    apc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .n(div_n_reg), .d(div_d_reg), .done(div_done), .q(div_q)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg <= 5'd2;
            dry_wet_reg     <= 8'd128;
            lfo_step_reg    <= 32'd38957;
            start_phase_reg <= 9'd0;
            depth_reg       <= 8'd100;
            feedback_reg    <= 8'sd0;
            out_gain_reg    <= 16'd4106;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[4:0];
                REG_DRY_WET:     dry_wet_reg     <= cfg_data[7:0];
                REG_LFO_STEP:    lfo_step_reg    <= cfg_data;
                REG_START_PHASE: start_phase_reg <= cfg_data[8:0];
                REG_DEPTH:       depth_reg       <= cfg_data[7:0];
                REG_FEEDBACK:    feedback_reg    <= cfg_data[7:0];
                REG_OUT_GAIN:    out_gain_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign n_new    = (stage_count_reg > STAGE_W'(MAX_STAGES)) ? STAGE_W'(MAX_STAGES)
                                                               : stage_count_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    // magnitude of the feedback amount, -128 gives 128
    assign fb_mag   = (feedback_reg < 0) ? 8'(-feedback_reg) : 8'(feedback_reg);
    // the quotient stays on the divider output until the next start
    assign out_load = (state_reg == S_ODIV) && (div_done || qrdy_reg)
                      && (!out_valid_reg || m_tready);
    assign old_sel  = valid_reg[stage_reg] ? mem_reg[stage_reg] : 32'sd0;
    assign mul_mag  = (mul_p < 0) ? -mul_p : mul_p;
    assign q_signed = neg_reg ? -mul_p_t'({1'b0, div_q}) : mul_p_t'({1'b0, div_q});
    assign nw       = sat32(trunc_gain(mul_p) + mul_p_t'(m_reg));
    assign m_sat    = sat32(mul_p_t'(m_reg));
    assign mix_sum  = mix1_reg + mul_p;
    assign ang      = angle_reg + div_q[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            valid_reg     <= '0;
            fv_reg        <= '0;
            g_reg         <= '0;
            cnt_reg       <= '0;
            angle_reg     <= '0;
            qrdy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        dry_reg  <= s_tdata;
                        n_reg    <= n_new;
                        prev_reg <= n_new;
                        // stages newly brought into the chain start from zero
                        for (int j = 0; j < MAX_STAGES; j++) begin
                            if (STAGE_W'(j) >= prev_reg && STAGE_W'(j) < n_new)
                                valid_reg[j] <= 1'b0;
                        end
                        angle_reg <= angle_reg + lfo_step_reg;
                        upd_reg   <= (cnt_reg == '0);
                        cnt_reg   <= (cnt_reg == UPD_CNT_W'(LFO_UPDATE_INTERVAL - 1))
                                     ? '0 : cnt_reg + 1'b1;
                        mul_a_reg <= (feedback_reg < 0) ? -mul_a_t'(fv_reg)
                                                        : mul_a_t'(fv_reg);
                        mul_b_reg     <= mul_b_t'(fb_mag);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_FBMUL;
                    end
                end
                S_FBMUL: begin
                    if (mul_done) begin
                        neg_reg       <= (mul_p < 0);
                        div_n_reg     <= mul_mag[DIV_N_W-1:0];
                        div_d_reg     <= DIV_D_W'(FB_DIVISOR);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_FBDIV;
                    end
                end
                S_FBDIV: begin
                    if (div_done) begin
                        m_reg <= 34'(dry_reg) + q_signed[33:0];
                        if (upd_reg) begin
                            div_n_reg     <= div_n_t'({start_phase_reg, 32'd0});
                            div_d_reg     <= DIV_D_W'(DEG_DIVISOR);
                            div_start_reg <= 1'b1;
                            state_reg     <= S_OFFDIV;
                        end else begin
                            stage_reg <= '0;
                            state_reg <= (n_reg == '0) ? S_MIXST : S_ST1;
                        end
                    end
                end
                S_OFFDIV: begin
                    if (div_done) begin
                        idx_reg   <= ang[31 -: LFO_IDX_W];
                        state_reg <= S_TAB;
                    end
                end
                S_TAB: begin
                    shape_reg <= LFO_TABLE[idx_reg];
                    state_reg <= S_DEPST;
                end
                S_DEPST: begin
                    mul_a_reg     <= mul_a_t'({1'b0, shape_reg});
                    mul_b_reg     <= mul_b_t'(depth_reg);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_DEPMUL;
                end
                S_DEPMUL: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_p[DIV_N_W-1:0];
                        div_d_reg     <= DIV_D_W'(MIX_DIVISOR);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DEPDIV;
                    end
                end
                S_DEPDIV: begin
                    if (div_done) begin
                        g_reg     <= SHAPE_W'(GAIN_ONE) - div_q[SHAPE_W-1:0];
                        stage_reg <= '0;
                        state_reg <= (n_reg == '0) ? S_MIXST : S_ST1;
                    end
                end
                S_ST1: begin
                    old_reg       <= old_sel;
                    mul_a_reg     <= mul_a_t'(old_sel);
                    mul_b_reg     <= mul_b_t'(g_reg);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_ST1W;
                end
                S_ST1W: begin
                    if (mul_done) begin
                        mem_reg[stage_reg]   <= nw;
                        valid_reg[stage_reg] <= 1'b1;
                        mul_a_reg     <= mul_a_t'(nw);
                        mul_b_reg     <= mul_b_t'(g_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_ST2W;
                    end
                end
                S_ST2W: begin
                    if (mul_done) begin
                        m_reg     <= 34'(sat32(mul_p_t'(old_reg) - trunc_gain(mul_p)));
                        stage_reg <= stage_reg + 1'b1;
                        state_reg <= (stage_reg + 1'b1 == n_reg) ? S_MIXST : S_ST1;
                    end
                end
                S_MIXST: begin
                    fv_reg        <= m_sat;
                    mul_a_reg     <= mul_a_t'(m_sat);
                    mul_b_reg     <= mul_b_t'(dry_wet_reg);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MIX1;
                end
                S_MIX1: begin
                    if (mul_done) begin
                        mix1_reg      <= mul_p;
                        mul_a_reg     <= mul_a_t'(dry_reg);
                        mul_b_reg     <= mul_b_t'(8'd255 - dry_wet_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MIX2;
                    end
                end
                S_MIX2: begin
                    if (mul_done) begin
                        mul_a_reg     <= mix_sum[MUL_A_W-1:0];
                        mul_b_reg     <= mul_b_t'(out_gain_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (mul_done) begin
                        // divide by 8192 by shift, then by 255 in the divider
                        neg_reg       <= (mul_p < 0);
                        div_n_reg     <= mul_mag[OUT_SHIFT +: DIV_N_W];
                        div_d_reg     <= DIV_D_W'(MIX_DIVISOR);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_ODIV;
                    end
                end
                S_ODIV: begin
                    if (out_load) begin
                        out_data_reg <= sat24(q_signed);
                        qrdy_reg     <= 1'b0;
                        state_reg    <= S_IDLE;
                    end else if (div_done) begin
                        qrdy_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `APC_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)
    `APC_ASSERT_NOW(a_stage_in_chain, state_reg == S_ST1, stage_reg < n_reg)
    `APC_ASSERT_NOW(a_gain_bound, 1'b1, g_reg <= SHAPE_W'(GAIN_ONE))
    `APC_ASSERT_NOW(a_chain_bound, state_reg != S_IDLE, n_reg <= STAGE_W'(MAX_STAGES))

endmodule
`default_nettype wire
